[rtl/aep_pkg.sv]
// ----------------------------------------------------------------------------
// Abbreviation entry parser package
// Shared payload types, status codes, register map and sizing constants.
// ----------------------------------------------------------------------------
package aep_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int PADDR_W         = 4;
    localparam int PDATA_W         = 32;

    // Result status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_END_TABLE  = 2'd1;
    localparam logic [1:0] ST_BAD_OFFSET = 2'd2;
    localparam logic [1:0] ST_NO_SECTION = 2'd3;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_SECTION_PRESENT = 2'd0;
    localparam logic [1:0] REG_SECTION_SIZE    = 2'd1;
    localparam logic [1:0] REG_UNIT_BASE       = 2'd2;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        start_req;
        logic [31:0] entry_offset;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] abbrev_code;
        logic [31:0] tag_value;
        logic        child_flag;
        logic [15:0] attr_count;
        logic [15:0] attr_list_offset;
        logic [15:0] entry_length;
    } out_t;

    typedef struct packed {
        logic        section_present;
        logic [31:0] section_size;
        logic [31:0] unit_base;
    } cfg_t;

    // A classified byte as it waits in the queue. For a start byte the
    // status already says whether the request is refused or may be parsed.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
        logic [1:0] start_status;
    } q_item_t;

endpackage

[rtl/abbrev_entry_parser.sv]
// ----------------------------------------------------------------------------
// Abbreviation entry parser
// Parses abbreviation section entries from a byte stream, one result per complete entry or refused request.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload   Transaction
// s_        in         in_t      one section byte, start flag and entry offset
// m_        out        out_t     one parsed entry or a refused request
// apb       in         32 bits   register write or read, no wait states
//
// One byte is taken per cycle while the queue has room; a result leaves at the
// earliest once its last byte has passed through the queue and the result register.
// The queue between the two ends holds QUEUE_DEPTH bytes, so input stalls only
// once the result register has been blocked for that many bytes.
// Reset is synchronous and clears the registers, the queue and the parse state.
// ----------------------------------------------------------------------------
module abbrev_entry_parser #(
    parameter int COUNT_WIDTH = aep_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = aep_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  aep_pkg::in_t                 s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output aep_pkg::out_t                m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aep_pkg::PADDR_W-1:0]  paddr,
    input  logic [aep_pkg::PDATA_W-1:0]  pwdata,
    output logic [aep_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import aep_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       reg_write;
    logic [1:0] reg_index;
    logic       q_full, q_push, q_pop, q_valid;
    q_item_t    push_item, head_item;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (reg_write) begin
            unique case (reg_index)
                REG_SECTION_PRESENT: cfg_next.section_present = pwdata[0];
                REG_SECTION_SIZE:    cfg_next.section_size    = pwdata;
                REG_UNIT_BASE:       cfg_next.unit_base       = pwdata;
                default:             cfg_next                 = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_SECTION_PRESENT: prdata = PDATA_W'(cfg_reg.section_present);
            REG_SECTION_SIZE:    prdata = cfg_reg.section_size;
            REG_UNIT_BASE:       prdata = cfg_reg.unit_base;
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    aep_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (push_item)
    );

    aep_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_item (head_item)
    );

    aep_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (head_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[rtl/aep_front.sv]
// ----------------------------------------------------------------------------
// Abbreviation entry parser front end
// Accepts input bytes and classifies start requests against the section.
// ----------------------------------------------------------------------------
module aep_front (
    input  logic             s_valid,
    output logic             s_ready,
    input  aep_pkg::in_t     s_data,
    input  aep_pkg::cfg_t    cfg,
    input  logic             q_full,
    output logic             q_push,
    output aep_pkg::q_item_t q_item
);
    import aep_pkg::*;

    logic [32:0] entry_pos;
    logic        pos_invalid;

    // The sum is formed one bit wider so that it never wraps.
    assign entry_pos   = 33'(cfg.unit_base) + 33'(s_data.entry_offset);
    assign pos_invalid = entry_pos >= 33'(cfg.section_size);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_item.data_byte = s_data.data_byte;
        q_item.start_req = s_data.start_req;
        if (!cfg.section_present) begin
            q_item.start_status = ST_NO_SECTION;
        end else if (pos_invalid) begin
            q_item.start_status = ST_BAD_OFFSET;
        end else if (s_data.data_byte == 8'd0) begin
            q_item.start_status = ST_END_TABLE;
        end else begin
            q_item.start_status = ST_OK;
        end
    end

endmodule

[rtl/aep_queue.sv]
// ----------------------------------------------------------------------------
// Abbreviation entry parser queue
// Short first-in first-out queue between the front end and the parser.
// ----------------------------------------------------------------------------
module aep_queue #(
    parameter int QUEUE_DEPTH = aep_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  aep_pkg::q_item_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output aep_pkg::q_item_t head_item
);
    import aep_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_item_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;

    assign full      = fill_reg == CNT_W'(QUEUE_DEPTH);
    assign not_empty = fill_reg != '0;
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/aep_back.sv]
// ----------------------------------------------------------------------------
// Abbreviation entry parser back end
// Decodes entries one byte per cycle while the result register is free, and holds the result for the consumer.
// ----------------------------------------------------------------------------
module aep_back #(
    parameter int COUNT_WIDTH = aep_pkg::COUNT_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  aep_pkg::q_item_t q_item,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output aep_pkg::out_t    m_data
);
    import aep_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_CODE  = 3'd1;
    localparam logic [2:0] PH_TAG   = 3'd2;
    localparam logic [2:0] PH_CHILD = 3'd3;
    localparam logic [2:0] PH_NAME  = 3'd4;
    localparam logic [2:0] PH_FORM  = 3'd5;

    localparam logic [5:0] SHIFT_STEP  = 6'd7;
    localparam logic [5:0] SHIFT_LIMIT = 6'd32;
    localparam logic [5:0] SHIFT_MAX   = 6'd35;

    logic [2:0]             phase_reg, phase_next;
    logic [31:0]            leb_accum_reg, leb_accum_next;
    logic [5:0]             leb_shift_reg, leb_shift_next;
    logic                   name_nonzero_reg, name_nonzero_next;
    logic [31:0]            held_code_reg, held_code_next;
    logic [31:0]            held_tag_reg, held_tag_next;
    logic                   held_children_reg, held_children_next;
    logic [COUNT_WIDTH-1:0] pair_count_reg, pair_count_next;
    logic [COUNT_WIDTH-1:0] attr_start_reg, attr_start_next;
    logic [COUNT_WIDTH-1:0] byte_count_reg, byte_count_next;
    logic                   m_valid_reg, m_valid_next;
    out_t                   m_data_reg, m_data_next;

    logic        out_free;
    logic [7:0]  b;
    logic [31:0] feed_accum;
    logic [5:0]  feed_shift;
    logic        feed_done;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v != '1) ? v + 1'b1 : v;
    endfunction

    function automatic logic [15:0] clamp16(input logic [COUNT_WIDTH-1:0] v);
        logic [32:0] wide;
        wide = 33'(v);
        return (wide > 33'd65535) ? 16'hFFFF : wide[15:0];
    endfunction

    // A new item can be taken whenever the result register is empty or
    // is being emptied in this cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = q_valid && out_free;
    assign b        = q_item.data_byte;

    // One ULEB128 step: bits at position 32 and above are dropped.
    assign feed_accum = (leb_shift_reg < SHIFT_LIMIT)
                      ? leb_accum_reg | (32'(b[6:0]) << leb_shift_reg[4:0])
                      : leb_accum_reg;
    assign feed_shift = (leb_shift_reg < SHIFT_MAX) ? leb_shift_reg + SHIFT_STEP
                                                    : SHIFT_MAX;
    assign feed_done  = !b[7];

    always_comb begin
        phase_next         = phase_reg;
        leb_accum_next     = leb_accum_reg;
        leb_shift_next     = leb_shift_reg;
        name_nonzero_next  = name_nonzero_reg;
        held_code_next     = held_code_reg;
        held_tag_next      = held_tag_reg;
        held_children_next = held_children_reg;
        pair_count_next    = pair_count_reg;
        attr_start_next    = attr_start_reg;
        byte_count_next    = byte_count_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_data_next        = m_data_reg;

        if (q_pop) begin
            if (q_item.start_req) begin
                // A start byte drops whatever entry was in progress.
                phase_next         = PH_IDLE;
                leb_accum_next     = '0;
                leb_shift_next     = '0;
                name_nonzero_next  = 1'b0;
                held_code_next     = '0;
                held_tag_next      = '0;
                held_children_next = 1'b0;
                pair_count_next    = '0;
                attr_start_next    = '0;
                byte_count_next    = '0;
                if (q_item.start_status != ST_OK) begin
                    m_valid_next       = 1'b1;
                    m_data_next        = '0;
                    m_data_next.status = q_item.start_status;
                end else begin
                    byte_count_next = COUNT_WIDTH'(1);
                    if (feed_done) begin
                        held_code_next = 32'(b[6:0]);
                        phase_next     = PH_TAG;
                    end else begin
                        leb_accum_next = 32'(b[6:0]);
                        leb_shift_next = SHIFT_STEP;
                        phase_next     = PH_CODE;
                    end
                end
            end else if (phase_reg != PH_IDLE && phase_reg <= PH_FORM) begin
                byte_count_next = sat_inc(byte_count_reg);
                if (phase_reg == PH_CHILD) begin
                    held_children_next = b == 8'd1;
                    attr_start_next    = byte_count_next;
                    phase_next         = PH_NAME;
                end else begin
                    leb_accum_next = feed_accum;
                    leb_shift_next = feed_shift;
                    if (feed_done) begin
                        leb_accum_next = '0;
                        leb_shift_next = '0;
                        unique case (phase_reg)
                            PH_CODE: begin
                                held_code_next = feed_accum;
                                phase_next     = PH_TAG;
                            end
                            PH_TAG: begin
                                held_tag_next = feed_accum;
                                phase_next    = PH_CHILD;
                            end
                            PH_NAME: begin
                                name_nonzero_next = feed_accum != '0;
                                phase_next        = PH_FORM;
                            end
                            default: begin
                                if (name_nonzero_reg && feed_accum != '0) begin
                                    pair_count_next = sat_inc(pair_count_reg);
                                    phase_next      = PH_NAME;
                                end else begin
                                    phase_next                   = PH_IDLE;
                                    m_valid_next                 = 1'b1;
                                    m_data_next.status           = ST_OK;
                                    m_data_next.abbrev_code      = held_code_reg;
                                    m_data_next.tag_value        = held_tag_reg;
                                    m_data_next.child_flag       = held_children_reg;
                                    m_data_next.attr_count       = clamp16(pair_count_reg);
                                    m_data_next.attr_list_offset = clamp16(attr_start_reg);
                                    m_data_next.entry_length     = clamp16(byte_count_next);
                                end
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            leb_accum_reg     <= '0;
            leb_shift_reg     <= '0;
            name_nonzero_reg  <= 1'b0;
            held_code_reg     <= '0;
            held_tag_reg      <= '0;
            held_children_reg <= 1'b0;
            pair_count_reg    <= '0;
            attr_start_reg    <= '0;
            byte_count_reg    <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            phase_reg         <= phase_next;
            leb_accum_reg     <= leb_accum_next;
            leb_shift_reg     <= leb_shift_next;
            name_nonzero_reg  <= name_nonzero_next;
            held_code_reg     <= held_code_next;
            held_tag_reg      <= held_tag_next;
            held_children_reg <= held_children_next;
            pair_count_reg    <= pair_count_next;
            attr_start_reg    <= attr_start_next;
            byte_count_reg    <= byte_count_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/aep_checker.sv]
// ----------------------------------------------------------------------------
// Abbreviation entry parser checker
// Port-level properties of the parser, attached to the top level by bind.
// ----------------------------------------------------------------------------
module aep_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          m_valid,
    input logic          m_ready,
    input aep_pkg::out_t m_data,
    input logic          pready
);
    import aep_pkg::*;

    // A stalled result must stay put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A refused request or end of table carries nothing but its status.
    a_refused_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |->
            m_data.abbrev_code == '0 && m_data.tag_value == '0 &&
            !m_data.child_flag && m_data.attr_count == '0 &&
            m_data.attr_list_offset == '0 && m_data.entry_length == '0)
        else $error("refused result carries entry fields");

    // A parsed entry has at least code, tag and children bytes before its pairs.
    a_ok_layout: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_OK |->
            m_data.attr_list_offset >= 16'd3 &&
            m_data.entry_length >= m_data.attr_list_offset)
        else $error("parsed entry has an impossible layout");

    a_no_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("register port inserted a wait state");

endmodule

bind abbrev_entry_parser aep_checker u_aep_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);

[sim/abbrev_entry_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Abbreviation entry parser testbench
// Feeds section bytes through the valid/ready input and predicts every entry
// result in a scoreboard. Each result transaction is checked field by field in
// order. The run steps through register settings, with random idling on both
// channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module abbrev_entry_parser_tb;
    import aep_pkg::*;

    localparam int SETTLE_CYCLES = QUEUE_DEPTH_DEF + 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 100;
    localparam int PRINT_LIMIT   = 50;

    typedef enum int {PH_IDLE, PH_CODE, PH_TAG, PH_CHILD, PH_NAME, PH_FORM} parse_phase_e;

    class abbrev_scoreboard;
        logic         sec_present;
        logic [31:0]  sec_size;
        logic [31:0]  tbl_base;
        parse_phase_e phase;
        logic [31:0]  leb_val;
        int           leb_pos;
        logic         name_set;
        logic [31:0]  code_q;
        logic [31:0]  tag_q;
        logic         children_q;
        logic [15:0]  pairs;
        logic [15:0]  list_off;
        logic [15:0]  nbytes;
        out_t         pending_entries[$];
        int           errors;
        int           results_seen;

        function new();
            sec_present  = 1'b0;
            sec_size     = '0;
            tbl_base     = '0;
            phase        = PH_IDLE;
            errors       = 0;
            results_seen = 0;
            clear_entry();
        endfunction

        function void clear_entry();
            leb_val    = '0;
            leb_pos    = 0;
            name_set   = 1'b0;
            code_q     = '0;
            tag_q      = '0;
            children_q = 1'b0;
            pairs      = '0;
            list_off   = '0;
            nbytes     = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_SECTION_PRESENT: sec_present = value[0];
                REG_SECTION_SIZE:    sec_size = value;
                REG_UNIT_BASE:       tbl_base = value;
                default: ;
            endcase
        endfunction

        function logic [15:0] sat16(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        // Bits that would land at position 32 or above are dropped.
        function bit leb_take(logic [7:0] b);
            if (leb_pos < 32)
                leb_val |= {25'd0, b[6:0]} << leb_pos;
            leb_pos = (leb_pos < 35) ? leb_pos + 7 : 35;
            return b[7] == 1'b0;
        endfunction

        function void leb_restart();
            leb_val = '0;
            leb_pos = 0;
        endfunction

        function void push_result(logic [1:0] st, bit full);
            out_t r;
            r = '0;
            r.status = st;
            if (full) begin
                r.abbrev_code      = code_q;
                r.tag_value        = tag_q;
                r.child_flag       = children_q;
                r.attr_count       = pairs;
                r.attr_list_offset = list_off;
                r.entry_length     = nbytes;
            end
            pending_entries.push_back(r);
        endfunction

        function void note_byte(in_t item);
            logic [32:0] pos;
            logic [7:0]  b;
            logic        form_set;
            b = item.data_byte;
            if (item.start_req) begin
                pos = {1'b0, tbl_base} + {1'b0, item.entry_offset};
                clear_entry();
                phase = PH_IDLE;
                if (!sec_present)
                    push_result(ST_NO_SECTION, 1'b0);
                else if (pos >= {1'b0, sec_size})
                    push_result(ST_BAD_OFFSET, 1'b0);
                else if (b == 8'h00)
                    push_result(ST_END_TABLE, 1'b0);
                else begin
                    nbytes = 16'd1;
                    if (leb_take(b)) begin
                        code_q = leb_val;
                        leb_restart();
                        phase = PH_TAG;
                    end else begin
                        phase = PH_CODE;
                    end
                end
                return;
            end
            // Bytes outside an entry are ignored.
            if (phase == PH_IDLE)
                return;
            nbytes = sat16(nbytes);
            case (phase)
                PH_CODE: if (leb_take(b)) begin
                    code_q = leb_val;
                    leb_restart();
                    phase = PH_TAG;
                end
                PH_TAG: if (leb_take(b)) begin
                    tag_q = leb_val;
                    leb_restart();
                    phase = PH_CHILD;
                end
                PH_CHILD: begin
                    children_q = (b == 8'd1);
                    list_off   = nbytes;
                    phase      = PH_NAME;
                end
                PH_NAME: if (leb_take(b)) begin
                    name_set = (leb_val != 0);
                    leb_restart();
                    phase = PH_FORM;
                end
                default: if (leb_take(b)) begin
                    form_set = (leb_val != 0);
                    leb_restart();
                    if (name_set && form_set) begin
                        pairs = sat16(pairs);
                        phase = PH_NAME;
                    end else begin
                        phase = PH_IDLE;
                        push_result(ST_OK, 1'b1);
                    end
                end
            endcase
        endfunction

        function void report_mismatch(string msg);
            errors++;
            // The count goes on, but the log is kept to a readable length.
            if (errors <= PRINT_LIMIT)
                $display("[%0t] result %0d: %s", $time, results_seen, msg);
        endfunction

        function void compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        endfunction

        function void check_entry(out_t got);
            out_t want;
            results_seen++;
            if (pending_entries.size() == 0) begin
                report_mismatch("result transaction with no entry outstanding");
                return;
            end
            want = pending_entries.pop_front();
            compare_field("status", 32'(got.status), 32'(want.status));
            compare_field("abbrev_code", got.abbrev_code, want.abbrev_code);
            compare_field("tag_value", got.tag_value, want.tag_value);
            compare_field("child_flag", 32'(got.child_flag), 32'(want.child_flag));
            compare_field("attr_count", 32'(got.attr_count), 32'(want.attr_count));
            compare_field("attr_list_offset", 32'(got.attr_list_offset),
                          32'(want.attr_list_offset));
            compare_field("entry_length", 32'(got.entry_length), 32'(want.entry_length));
        endfunction

        function int pending();
            return pending_entries.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_t                  s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_t                 m_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    abbrev_scoreboard sb;
    in_t              byte_q[$];
    bit               idle_on;
    bit               hold_req;
    logic             cfg_present;
    logic [31:0]      cfg_size;
    logic [31:0]      cfg_base;

    abbrev_entry_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic void push_byte(logic [7:0] b, bit st, logic [31:0] off);
        in_t it;
        it.data_byte    = b;
        it.start_req    = st;
        it.entry_offset = st ? off : $urandom();
        byte_q.push_back(it);
    endfunction

    function automatic int rand_leb_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 1;
        if (r < 80) return 2;
        if (r < 92) return 3;
        if (r < 97) return 5;
        return $urandom_range(6, 8);
    endfunction

    // A nonzero value is guaranteed through the first byte, which is never dropped.
    function automatic void push_leb(int len, bit st, logic [31:0] off, bit nonzero);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = (i == 0 && nonzero) ? 8'($urandom_range(1, 127)) : 8'($urandom_range(0, 127));
            if (i < len - 1)
                b[7] = 1'b1;
            push_byte(b, st && i == 0, off);
        end
    endfunction

    function automatic void push_entry(logic [31:0] off, int npairs, bit whole);
        int first;
        int cut;
        int r;
        first = byte_q.size();
        push_leb(rand_leb_len(), 1'b1, off, 1'b1);
        push_leb(rand_leb_len(), 1'b0, '0, 1'b0);
        r = $urandom_range(0, 19);
        push_byte((r < 9) ? 8'd1 : (r < 18) ? 8'd0 : 8'($urandom()), 1'b0, '0);
        repeat (npairs) begin
            push_leb(rand_leb_len(), 1'b0, '0, 1'b1);
            push_leb(rand_leb_len(), 1'b0, '0, 1'b1);
        end
        // The list ends on whichever of name or form is zero.
        case ($urandom_range(0, 5))
            3: begin
                push_byte(8'h80, 1'b0, '0);
                push_byte(8'h00, 1'b0, '0);
                push_byte(8'h00, 1'b0, '0);
            end
            4: begin
                push_leb(rand_leb_len(), 1'b0, '0, 1'b1);
                push_byte(8'h00, 1'b0, '0);
            end
            5: begin
                push_byte(8'h00, 1'b0, '0);
                push_leb(rand_leb_len(), 1'b0, '0, 1'b1);
            end
            default: begin
                push_byte(8'h00, 1'b0, '0);
                push_byte(8'h00, 1'b0, '0);
            end
        endcase
        if (!whole) begin
            cut = $urandom_range(1, byte_q.size() - first - 1);
            repeat (cut) void'(byte_q.pop_back());
        end
    endfunction

    // Offsets below room pass the size check; room is zero when none can.
    function automatic logic [31:0] pick_offset(bit want_ok);
        logic [31:0] room;
        room = (cfg_size > cfg_base) ? cfg_size - cfg_base : '0;
        if (room == 0)
            return $urandom();
        if (want_ok) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return room - 1;
                default: return $urandom_range(room - 1, 0);
            endcase
        end
        case ($urandom_range(0, 3))
            0: return 32'hFFFF_FFFF;
            1: return room;
            default: return $urandom_range(32'hFFFF_FFFF, room);
        endcase
    endfunction

    task automatic send_stream();
        int gap;
        foreach (byte_q[i]) begin
            if (idle_on && $urandom_range(0, 9) == 0) begin
                s_valid <= 1'b0;
                gap = $urandom_range(1, 6);
                repeat (gap) @(negedge aclk);
            end
            s_valid <= 1'b1;
            s_data  <= byte_q[i];
            do @(posedge aclk); while (s_ready !== 1'b1);
            sb.note_byte(byte_q[i]);
            @(negedge aclk);
        end
        s_valid <= 1'b0;
        byte_q.delete();
    endtask

    // Bytes that give no result may still sit in the queue when the last
    // result leaves, hence the extra cycles.
    task automatic wait_drained();
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value, logic [31:0] readback);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_reg(idx, value);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== readback)
            sb.report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                         idx, got, readback));
        @(negedge aclk);
    endtask

    task automatic apply_config(logic present, logic [31:0] size, logic [31:0] base);
        logic [31:0] word;
        word    = $urandom();
        word[0] = present;
        write_reg(REG_SECTION_PRESENT, word, {31'd0, present});
        write_reg(REG_SECTION_SIZE, size, size);
        write_reg(REG_UNIT_BASE, base, base);
        cfg_present = present;
        cfg_size    = size;
        cfg_base    = base;
    endtask

    task automatic run_random(int n_items);
        int  strays;
        int  kind;
        bit  block_idle;
        strays     = 0;
        block_idle = 1'b1;
        while (byte_q.size() - strays < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                if (block_idle) begin
                    push_byte(8'($urandom()), 1'b0, '0);
                    strays++;
                end
            end else if (kind < 18) begin
                push_byte(8'h00, 1'b1, pick_offset(1'b1));
                block_idle = 1'b1;
            end else if (kind < 28) begin
                push_byte(8'($urandom()), 1'b1, pick_offset(1'b0));
                block_idle = 1'b1;
            end else if (kind < 36) begin
                push_entry(pick_offset(1'b1), $urandom_range(0, 4), 1'b0);
                block_idle = 1'b0;
            end else begin
                push_entry(pick_offset(1'b1),
                           ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                       : $urandom_range(0, 6), 1'b1);
                block_idle = 1'b1;
            end
        end
        send_stream();
        wait_drained();
    endtask

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin : result_sink
        int burst;
        int hold;
        burst   = 0;
        hold    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold     = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else if (burst > 0) begin
                m_ready <= 1'b0;
                burst--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                burst = $urandom_range(0, 5);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
            sb.check_entry(m_data);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("abbrev_entry_parser: mismatch");
        $finish;
    end

    initial begin : stimulus
        logic        rnd_present;
        logic [31:0] rnd_size;
        logic [31:0] rnd_base;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        cfg_present = 1'b0;
        cfg_size    = '0;
        cfg_base    = '0;
        sb          = new();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Registers still at their reset values: every request finds no section.
        push_byte(8'h00, 1'b1, '0);
        push_byte(8'h01, 1'b1, 32'hFFFF_FFFF);
        send_stream();
        wait_drained();

        apply_config(1'b1, 32'h0000_1000, '0);
        push_byte(8'h00, 1'b1, '0);
        push_byte(8'h01, 1'b1, 32'h0000_1000);
        push_byte(8'h00, 1'b1, 32'hFFFF_FFFF);
        // An entry cut short by a new start gives no result of its own.
        push_byte(8'h81, 1'b1, 32'h0000_0FFF);
        // Six-byte code overflows 32 bits; two-byte tag; one pair, then a zero name.
        push_byte(8'hFF, 1'b1, 32'h0000_0FFF);
        repeat (4) push_byte(8'hFF, 1'b0, '0);
        push_byte(8'h7F, 1'b0, '0);
        push_byte(8'h80, 1'b0, '0);
        push_byte(8'h01, 1'b0, '0);
        push_byte(8'h01, 1'b0, '0);
        push_byte(8'h05, 1'b0, '0);
        push_byte(8'h0B, 1'b0, '0);
        push_byte(8'h00, 1'b0, '0);
        push_byte(8'h21, 1'b0, '0);
        push_byte(8'hAA, 1'b0, '0);
        // Zero tag, children byte other than one, zero form.
        push_byte(8'h7F, 1'b1, '0);
        push_byte(8'h00, 1'b0, '0);
        push_byte(8'h02, 1'b0, '0);
        push_byte(8'h03, 1'b0, '0);
        push_byte(8'h00, 1'b0, '0);
        send_stream();
        wait_drained();

        // Only offset zero fits; offset one reaches the size and larger offsets overflow past 32 bits.
        apply_config(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        run_random(60);

        // Single-byte results while the receiver holds off, so the input stalls.
        hold_req = 1'b1;
        repeat (30) begin
            if ($urandom_range(0, 1) == 0)
                push_byte(8'h00, 1'b1, pick_offset(1'b1));
            else
                push_byte(8'($urandom()), 1'b1, pick_offset(1'b0));
        end
        send_stream();
        wait_drained();

        apply_config(1'b1, '0, '0);
        run_random(30);
        apply_config(1'b0, 32'hFFFF_FFFF, '0);
        run_random(30);

        repeat (5) begin
            rnd_present = ($urandom_range(0, 7) != 0);
            case ($urandom_range(0, 3))
                0: rnd_size = 32'hFFFF_FFFF;
                1: rnd_size = $urandom_range(1, 64);
                default: rnd_size = $urandom();
            endcase
            case ($urandom_range(0, 3))
                0: rnd_base = '0;
                1: rnd_base = $urandom();
                default: rnd_base = (rnd_size > 1) ? $urandom_range(rnd_size - 1, 0) : '0;
            endcase
            apply_config(rnd_present, rnd_size, rnd_base);
            idle_on = ($urandom_range(0, 3) != 0);
            run_random(130);
        end

        idle_on = 1'b0;
        apply_config(1'b1, 32'hFFFF_FFFF, $urandom());
        run_random(150);

        if (sb.errors == 0)
            $display("abbrev_entry_parser: match");
        else
            $display("abbrev_entry_parser: mismatch");
        $finish;
    end
endmodule

[filelist.f]
rtl/aep_pkg.sv
rtl/aep_front.sv
rtl/aep_queue.sv
rtl/aep_back.sv
rtl/abbrev_entry_parser.sv
rtl/aep_checker.sv
sim/abbrev_entry_parser_tb.sv
